/* hdl/hcr_pkg.sv */
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared types and constants for the cubic Hermite resampler.
// ----------------------------------------------------------------------------
package hcr_pkg;

	localparam int SAMPLE_W = 16;
	localparam int RATE_W   = 20;
	localparam int FILL_W   = 3;
	localparam int CNT_W    = 7;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// doubled Hermite coefficient widths (A as magnitude)
	localparam int CA_MAG_W = 19;
	localparam int CB_W     = 20;
	localparam int CC_W     = 17;

	localparam logic [FILL_W-1:0] FILL_FULL    = 3'd4;
	localparam logic [CNT_W-1:0]  MAX_RESULTS  = 7'd64;
	localparam logic [RATE_W-1:0] RATE_RESET   = 20'd65536;
	localparam int unsigned       SAT_HI_MAG   = 32767;
	localparam int unsigned       SAT_LO_MAG   = 32768;
	localparam logic signed [SAMPLE_W-1:0] SAT_HI = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_LO = 16'sh8000;

	// register index
	localparam logic [PADDR_W-3:0] REG_RATE_STEP = 1'b0;

	// Horner passes
	localparam logic [1:0] PASS_V1 = 2'd0;
	localparam logic [1:0] PASS_V2 = 2'd1;
	localparam logic [1:0] PASS_V3 = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       restart;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       last_of_run;
	} result_t;

	typedef struct packed {
		logic       accept;
		logic       coef;
		logic       mul;
		logic       acc;
		logic       fin;
		logic       load_out;
		logic       last;
		logic [1:0] pass;
	} hcr_cmd_t;

	typedef struct packed {
		logic rate_one;
		logic fill_done;
		logic phase_lt_one;
		logic out_free;
	} hcr_status_t;

endpackage

/* hdl/hermite_cubic_resampler_unit.sv */
// ----------------------------------------------------------------------------
// hermite_cubic_resampler_unit
// Four-point cubic Hermite sample-rate converter with APB rate register.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (sample_valid / sample_stall / sample_data) takes one
//    int16 sample per transfer; restart=1 empties the window and zeroes the
//    phase before the sample is taken.
//  - Output channel (result_valid / result_stall / result_data) gives zero
//    or more interpolated samples per input; last_of_run flags the final one.
//  - rate_step at byte address 0 (Q4.16, 0x10000 = pass-through). Write it
//    only while the block is idle.
//  - Steps: a filling sample is only taken; a pass-through sample adds a
//    result-register load. A resampled input adds a coefficient step, then
//    per result 3 multiply/add passes of the one shared multiplier, a final
//    scale/clamp step and a result-register load, up to 64 results per input.
//  - The last result sits in the output register while the next input is
//    taken. A stalled receiver holds the sequencer in its write or pass-through step.
//  - Reset clears window, fill count, phase and rate (back to 1.0); no
//    result is pending after reset.
// ----------------------------------------------------------------------------
module hermite_cubic_resampler_unit import hcr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample input
	input  logic               sample_valid,
	output logic               sample_stall,
	input  sample_t            sample_data,
	// result output
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result_data,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [RATE_W-1:0] rate_q;
	logic              reg_hit;
	hcr_cmd_t          cmd;
	hcr_status_t       status;

	// register decode: word index sits above the byte offset
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_RATE_STEP);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {{(PDATA_W-RATE_W){1'b0}}, rate_q} : '0;

	// rate register, written on the APB access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			rate_q <= pwdata[RATE_W-1:0];
		end
	end

	// sequencer
	hcr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// window, phase, Horner arithmetic and result register
	hcr_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (sample_data),
		.rate         (rate_q),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

/* hdl/hcr_datapath.sv */
// ----------------------------------------------------------------------------
// hcr_datapath
// Window, phase, coefficient registers, shared Horner multiplier and the
// result register.
// ----------------------------------------------------------------------------
module hcr_datapath import hcr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hcr_cmd_t            cmd,
	input  sample_t             sample,
	input  logic [RATE_W-1:0]   rate,
	output hcr_status_t         status,
	output logic                result_valid,
	input  logic                result_stall,
	output result_t             result_data
);

	localparam int PH_W   = ((FRAC_BITS > RATE_W) ? FRAC_BITS : RATE_W) + 2;
	localparam int MAG_W  = FRAC_BITS + 22;
	localparam int V_W    = FRAC_BITS + 23;
	localparam int PROD_W = MAG_W + FRAC_BITS;
	localparam int QW     = V_W - FRAC_BITS - 2;
	localparam logic [PH_W-1:0] ONE = PH_W'(1) << FRAC_BITS;

	logic signed [SAMPLE_W-1:0] win_q [4];
	logic [FILL_W-1:0]          fill_q;
	logic [PH_W-1:0]            phase_q;
	logic [CA_MAG_W-1:0]        ca_mag_q;
	logic                       ca_neg_q;
	logic signed [CB_W-1:0]     cb_q;
	logic signed [CC_W-1:0]     cc_q;
	logic [MAG_W-1:0]           mag_q;
	logic                       neg_q;
	logic signed [V_W-1:0]      acc_q;
	logic [PROD_W-1:0]          prod_q;
	logic signed [SAMPLE_W-1:0] y_q;
	result_t                    res_q;
	logic                       res_valid_q;

	// accept-time values
	logic [FILL_W-1:0] fill_eff;
	logic [PH_W-1:0]   phase_eff, phase_dec, rate_ext;
	logic              was_full;

	always_comb begin
		fill_eff  = sample.restart ? '0 : fill_q;
		phase_eff = sample.restart ? '0 : phase_q;
		phase_dec = (phase_eff >= ONE) ? phase_eff - ONE : '0;
		was_full  = (fill_eff == FILL_FULL);
		rate_ext  = {{(PH_W-RATE_W){1'b0}}, rate};
	end

	assign status.rate_one     = (rate_ext == ONE);
	assign status.fill_done    = (fill_eff == FILL_FULL) || (fill_eff == FILL_FULL - 3'd1);
	assign status.phase_lt_one = (phase_q < ONE);
	assign status.out_free     = !res_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) win_q[i] <= '0;
			fill_q  <= '0;
			phase_q <= '0;
		end else if (cmd.accept) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= sample.sample_in;
			fill_q   <= was_full ? fill_eff : fill_eff + 3'd1;
			phase_q  <= (was_full && !status.rate_one) ? phase_dec : phase_eff;
		end else if (cmd.fin) begin
			phase_q <= phase_q + rate_ext;
		end
	end

	// coefficients, doubled: A = 3(x0-x1)-xm1+x2, B = 4x1+2xm1-5x0-x2, C = x1-xm1
	logic signed [21:0] xm1, x0, x1, x2, dx, ca, cb, cc, ca_abs;

	always_comb begin
		xm1    = 22'(win_q[0]);
		x0     = 22'(win_q[1]);
		x1     = 22'(win_q[2]);
		x2     = 22'(win_q[3]);
		dx     = x0 - x1;
		ca     = (dx <<< 1) + dx - xm1 + x2;
		cb     = (x1 <<< 2) + (xm1 <<< 1) - ((x0 <<< 2) + x0) - x2;
		cc     = x1 - xm1;
		ca_abs = ca[21] ? -ca : ca;
	end

	always_ff @(posedge clk) begin
		if (cmd.coef) begin
			ca_mag_q <= ca_abs[CA_MAG_W-1:0];
			ca_neg_q <= ca[21];
			cb_q     <= cb[CB_W-1:0];
			cc_q     <= cc[CC_W-1:0];
		end
	end

	// shared multiplier: magnitude times phase fraction
	logic [MAG_W-1:0] mul_a;

	assign mul_a = (cmd.pass == PASS_V1) ? {{(MAG_W-CA_MAG_W){1'b0}}, ca_mag_q} : mag_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= mul_a * phase_q[FRAC_BITS-1:0];
	end

	// accumulate: sign restore, truncating shift, add next coefficient
	logic [MAG_W-1:0]      prod_sh;
	logic signed [V_W-1:0] term, tv, addend, v, v_abs;
	logic                  neg_sel;

	always_comb begin
		neg_sel = (cmd.pass == PASS_V1) ? ca_neg_q : neg_q;
		prod_sh = (cmd.pass == PASS_V1) ? prod_q[MAG_W-1:0] : prod_q[PROD_W-1:FRAC_BITS];
		term    = {1'b0, prod_sh};
		tv      = neg_sel ? -term : term;
		case (cmd.pass)
			PASS_V1: addend = {{(V_W-CB_W-FRAC_BITS){cb_q[CB_W-1]}}, cb_q, {FRAC_BITS{1'b0}}};
			PASS_V2: addend = {{(V_W-CC_W-FRAC_BITS){cc_q[CC_W-1]}}, cc_q, {FRAC_BITS{1'b0}}};
			default: addend = '0;
		endcase
		v     = tv + addend;
		v_abs = v[V_W-1] ? -v : v;
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			acc_q <= v;
			neg_q <= v[V_W-1];
			mag_q <= v_abs[MAG_W-1:0];
		end
	end

	// final: add x0, divide by 2^(F+1) toward zero, clamp
	logic signed [V_W-1:0]      t, t_abs;
	logic [QW-1:0]              q, q_neg;
	logic signed [SAMPLE_W-1:0] y;

	always_comb begin
		t     = acc_q + {{(V_W-SAMPLE_W-FRAC_BITS-1){win_q[1][SAMPLE_W-1]}}, win_q[1],
			{(FRAC_BITS+1){1'b0}}};
		t_abs = t[V_W-1] ? -t : t;
		q     = t_abs[V_W-2:FRAC_BITS+1];
		q_neg = QW'(0) - q;
		if (!t[V_W-1]) begin
			y = (q > QW'(SAT_HI_MAG)) ? SAT_HI : q[SAMPLE_W-1:0];
		end else begin
			y = (q > QW'(SAT_LO_MAG)) ? SAT_LO : q_neg[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) y_q <= sample.sample_in;
		else if (cmd.fin) y_q <= y;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.sample_out  <= y_q;
			res_q.last_of_run <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

endmodule

/* hdl/hcr_ctrl.sv */
// ----------------------------------------------------------------------------
// hcr_ctrl
// Sequencer: fill / pass-through decisions, Horner passes, result count.
// ----------------------------------------------------------------------------
module hcr_ctrl import hcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  hcr_status_t status,
	output hcr_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_COEF  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_ACC   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_WRITE = 3'd5;
	localparam logic [2:0] S_PASS  = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [1:0]       pass_q;
	logic [CNT_W-1:0] cnt_q;
	logic             more;

	assign more = status.phase_lt_one && (cnt_q < MAX_RESULTS);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.pass     = pass_q;
		sample_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = sample_valid;
				if (sample_valid) begin
					if (status.rate_one) state_d = S_PASS;
					else if (status.fill_done) state_d = S_COEF;
				end
			end
			S_COEF: begin
				cmd.coef = 1'b1;
				state_d  = status.phase_lt_one ? S_MUL : S_IDLE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = (pass_q == PASS_V3) ? S_FIN : S_MUL;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.last     = !more;
				cmd.load_out = status.out_free;
				if (status.out_free) state_d = more ? S_MUL : S_IDLE;
			end
			S_PASS: begin
				cmd.last     = 1'b1;
				cmd.load_out = status.out_free;
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= PASS_V1;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ACC) pass_q <= (pass_q == PASS_V3) ? PASS_V1 : pass_q + 2'd1;
			if (state_q == S_COEF) cnt_q <= '0;
			else if (state_q == S_FIN) cnt_q <= cnt_q + 7'd1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_RESULTS)
		else $error("result count past limit");

	a_mul_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> status.phase_lt_one)
		else $error("multiply with phase not below one");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free)
		else $error("result register overwritten");

	a_pass_range: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q == PASS_V1 || pass_q == PASS_V2 || pass_q == PASS_V3)
		else $error("bad Horner pass");

endmodule
